FILE: rtl/hcl_pkg.sv
// Shared types and constants for the Huffman code length builder.
// No dependencies.
package hcl_pkg;

   localparam int SYM_W     = 9;
   localparam int FREQ_IN_W = 32;
   localparam int LEN_W     = 9;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_READ = 1'b1;

   localparam logic ST_OK    = 1'b0;
   localparam logic ST_EMPTY = 1'b1;

   typedef enum logic [1:0] {
      CH_HOLD,
      CH_CLEAR,
      CH_INSERT,
      CH_POP
   } chain_op_type;

endpackage

FILE: rtl/huffman_code_length_builder.sv
// Huffman code length builder. After reset the symbol index (512 entries by default) is
// cleared with requests stalled. A load request steps through symbol index lookup, entry
// check and write. The first read request of a job builds the tree: each loaded symbol is
// read and inserted into the sorted cell chain, then L-1 merges for L symbols each pop the
// two least nodes and insert their parent, one insert at a time. Every read then walks the
// tree from a node stack: it descends to reach the next leaf and pops the stack after a
// non-final leaf. Depth of the tree limits the walk. Loads during readout are dropped.
// Depends on hcl_pkg, hcl_chain.
module huffman_code_length_builder #(
   parameter int MAX_SYMBOLS = 512,
   parameter int FREQ_BITS   = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_action,
   input  logic [hcl_pkg::SYM_W-1:0]     req_symbol,
   input  logic [hcl_pkg::FREQ_IN_W-1:0] req_frequency,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [hcl_pkg::SYM_W-1:0]     rsp_symbol_out,
   output logic [hcl_pkg::LEN_W-1:0]     rsp_code_length,
   output logic                          rsp_last_leaf,
   output logic                          rsp_status
);
   import hcl_pkg::*;

   localparam int LEAF_CAP = (MAX_SYMBOLS < (1 << SYM_W)) ? MAX_SYMBOLS : (1 << SYM_W);
   localparam int SLOT_W   = $clog2(LEAF_CAP);
   localparam int CNT_W    = $clog2(LEAF_CAP + 1);
   localparam int NODE_CAP = 2 * LEAF_CAP - 1;
   localparam int NID_W    = $clog2(NODE_CAP);
   localparam int WGT_W    = FREQ_BITS + SLOT_W;
   localparam int DATA_W   = WGT_W + SYM_W + NID_W;
   localparam int LIST_W   = SYM_W + FREQ_BITS;
   localparam int STK_W    = NID_W + LEN_W;

   typedef enum logic [13:0] {
      S_IDLE      = 14'b00000000000001,
      S_LD_LOOK   = 14'b00000000000010,
      S_LD_WRITE  = 14'b00000000000100,
      S_EMPTY     = 14'b00000000001000,
      S_FILL_RD   = 14'b00000000010000,
      S_FILL_INS  = 14'b00000000100000,
      S_MRG_A     = 14'b00000001000000,
      S_MRG_B     = 14'b00000010000000,
      S_MRG_C     = 14'b00000100000000,
      S_WALK_CHK  = 14'b00001000000000,
      S_WALK_DESC = 14'b00010000000000,
      S_WALK_LEAF = 14'b00100000000000,
      S_POP       = 14'b01000000000000,
      S_INIT      = 14'b10000000000000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                readout_ff, readout_in;
   logic [SYM_W-1:0]    sym_ff, sym_in;
   logic [FREQ_BITS-1:0] freq_ff, freq_in;
   logic [SLOT_W-1:0]   k_ff, k_in;
   logic [NID_W-1:0]    next_id_ff, next_id_in;
   logic [DATA_W-1:0]   a_ff, a_in;
   logic [DATA_W-1:0]   parent_ff, parent_in;
   logic [NID_W-1:0]    cur_id_ff, cur_id_in;
   logic [LEN_W-1:0]    cur_depth_ff, cur_depth_in;
   logic [SLOT_W-1:0]   sp_ff, sp_in;
   logic [SLOT_W-1:0]   out_cnt_ff, out_cnt_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]    rsp_sym_ff, rsp_sym_in;
   logic [LEN_W-1:0]    rsp_len_ff, rsp_len_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_status_ff, rsp_status_in;

   logic [SLOT_W-1:0]   idx_mem   [LEAF_CAP];
   logic [LIST_W-1:0]   list_mem  [LEAF_CAP];
   logic [2*NID_W-1:0]  child_mem [NODE_CAP];
   logic [STK_W-1:0]    stack_mem [LEAF_CAP];

   logic [SLOT_W-1:0]   idx_rd_ff;
   logic [LIST_W-1:0]   list_rd_ff;
   logic [2*NID_W-1:0]  child_rd_ff;
   logic [STK_W-1:0]    stack_rd_ff;

   logic                idx_we, list_we, child_we, stack_we;
   logic [SLOT_W-1:0]   idx_raddr, idx_waddr, list_raddr, list_waddr;

   chain_op_type        chain_op;
   logic [DATA_W-1:0]   ins_data;
   logic                head1_valid;
   logic [DATA_W-1:0]   head0_data;

   logic                req_acc, out_free, sym_ok, hit, is_leaf, last, k_last;
   logic [SYM_W-1:0]    list_sym, a_sym, h_sym;
   logic [FREQ_BITS-1:0] list_freq;
   logic [WGT_W-1:0]    a_wgt, h_wgt;
   logic [NID_W-1:0]    a_id, h_id;

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign sym_ok    = (32'(req_symbol) < 32'(MAX_SYMBOLS));

   assign list_sym  = list_rd_ff[LIST_W-1:FREQ_BITS];
   assign list_freq = list_rd_ff[FREQ_BITS-1:0];
   assign a_wgt     = a_ff[DATA_W-1:NID_W+SYM_W];
   assign a_sym     = a_ff[NID_W+SYM_W-1:NID_W];
   assign a_id      = a_ff[NID_W-1:0];
   assign h_wgt     = head0_data[DATA_W-1:NID_W+SYM_W];
   assign h_sym     = head0_data[NID_W+SYM_W-1:NID_W];
   assign h_id      = head0_data[NID_W-1:0];

   assign hit     = (CNT_W'(idx_rd_ff) < count_ff) && (list_sym == sym_ff);
   assign is_leaf = (cur_id_ff < NID_W'(count_ff));
   assign last    = ((CNT_W'(out_cnt_ff) + CNT_W'(1)) >= count_ff);
   assign k_last  = ((CNT_W'(k_ff) + CNT_W'(1)) == count_ff);

   assign idx_raddr  = (state_ff == S_IDLE) ? req_symbol[SLOT_W-1:0] : sym_ff[SLOT_W-1:0];
   assign idx_waddr  = (state_ff == S_INIT) ? k_ff : sym_ff[SLOT_W-1:0];
   assign list_waddr = hit ? idx_rd_ff : count_ff[SLOT_W-1:0];

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      readout_in    = readout_ff;
      sym_in        = sym_ff;
      freq_in       = freq_ff;
      k_in          = k_ff;
      next_id_in    = next_id_ff;
      a_in          = a_ff;
      parent_in     = parent_ff;
      cur_id_in     = cur_id_ff;
      cur_depth_in  = cur_depth_ff;
      sp_in         = sp_ff;
      out_cnt_in    = out_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sym_in    = rsp_sym_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      idx_we        = 1'b0;
      list_we       = 1'b0;
      child_we      = 1'b0;
      stack_we      = 1'b0;
      list_raddr    = cur_id_ff[SLOT_W-1:0];
      chain_op      = CH_HOLD;
      ins_data      = parent_ff;

      unique case (state_ff)
         S_INIT: begin
            idx_we = 1'b1;
            k_in   = k_ff + SLOT_W'(1);
            if (k_ff == SLOT_W'(LEAF_CAP - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               if (req_action == ACT_LOAD) begin
                  if (!readout_ff && sym_ok) begin
                     sym_in   = req_symbol;
                     freq_in  = FREQ_BITS'(req_frequency);
                     state_in = S_LD_LOOK;
                  end
               end else if (readout_ff) begin
                  state_in = S_WALK_CHK;
               end else if (count_ff == '0) begin
                  state_in = S_EMPTY;
               end else begin
                  k_in       = '0;
                  next_id_in = NID_W'(count_ff);
                  state_in   = S_FILL_RD;
               end
            end
         end
         S_LD_LOOK: begin
            list_raddr = idx_rd_ff;
            state_in   = S_LD_WRITE;
         end
         S_LD_WRITE: begin
            list_we = 1'b1;
            if (!hit) begin
               idx_we   = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
            state_in = S_IDLE;
         end
         S_EMPTY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sym_in    = '0;
               rsp_len_in    = '0;
               rsp_last_in   = 1'b0;
               rsp_status_in = ST_EMPTY;
               state_in      = S_IDLE;
            end
         end
         S_FILL_RD: begin
            list_raddr = k_ff;
            state_in   = S_FILL_INS;
         end
         S_FILL_INS: begin
            chain_op = CH_INSERT;
            ins_data = {WGT_W'(list_freq), list_sym, NID_W'(k_ff)};
            if (k_last) begin
               state_in = S_MRG_A;
            end else begin
               k_in     = k_ff + SLOT_W'(1);
               state_in = S_FILL_RD;
            end
         end
         S_MRG_A: begin
            if (head1_valid) begin
               a_in     = head0_data;
               chain_op = CH_POP;
               state_in = S_MRG_B;
            end else begin
               chain_op     = CH_CLEAR;
               cur_id_in    = h_id;
               cur_depth_in = '0;
               sp_in        = '0;
               out_cnt_in   = '0;
               readout_in   = 1'b1;
               state_in     = S_WALK_CHK;
            end
         end
         S_MRG_B: begin
            parent_in  = {a_wgt + h_wgt, (a_sym < h_sym) ? a_sym : h_sym, next_id_ff};
            child_we   = 1'b1;
            next_id_in = next_id_ff + NID_W'(1);
            chain_op   = CH_POP;
            state_in   = S_MRG_C;
         end
         S_MRG_C: begin
            chain_op = CH_INSERT;
            state_in = S_MRG_A;
         end
         S_WALK_CHK: begin
            state_in = is_leaf ? S_WALK_LEAF : S_WALK_DESC;
         end
         S_WALK_DESC: begin
            stack_we     = 1'b1;
            sp_in        = sp_ff + SLOT_W'(1);
            cur_id_in    = child_rd_ff[2*NID_W-1:NID_W];
            cur_depth_in = cur_depth_ff + LEN_W'(1);
            state_in     = S_WALK_CHK;
         end
         S_WALK_LEAF: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sym_in    = list_sym;
               rsp_len_in    = cur_depth_ff;
               rsp_last_in   = last;
               rsp_status_in = ST_OK;
               if (last) begin
                  count_in   = '0;
                  readout_in = 1'b0;
                  state_in   = S_IDLE;
               end else begin
                  out_cnt_in = out_cnt_ff + SLOT_W'(1);
                  state_in   = S_POP;
               end
            end
         end
         S_POP: begin
            cur_id_in    = stack_rd_ff[STK_W-1:LEN_W];
            cur_depth_in = stack_rd_ff[LEN_W-1:0];
            sp_in        = sp_ff - SLOT_W'(1);
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         count_ff     <= '0;
         readout_ff   <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         readout_ff   <= readout_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff        <= sym_in;
      freq_ff       <= freq_in;
      next_id_ff    <= next_id_in;
      a_ff          <= a_in;
      parent_ff     <= parent_in;
      cur_id_ff     <= cur_id_in;
      cur_depth_ff  <= cur_depth_in;
      sp_ff         <= sp_in;
      out_cnt_ff    <= out_cnt_in;
      rsp_sym_ff    <= rsp_sym_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   // symbol -> slot; an entry counts only if the slot points back at the symbol
   always_ff @(posedge clock) begin
      if (idx_we) begin
         idx_mem[idx_waddr] <= count_ff[SLOT_W-1:0];
      end
      idx_rd_ff <= idx_mem[idx_raddr];
   end

   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem[list_waddr] <= {sym_ff, freq_ff};
      end
      list_rd_ff <= list_mem[list_raddr];
   end

   always_ff @(posedge clock) begin
      if (child_we) begin
         child_mem[next_id_ff] <= {a_id, h_id};
      end
      child_rd_ff <= child_mem[cur_id_ff];
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[sp_ff] <= {child_rd_ff[NID_W-1:0], cur_depth_ff + LEN_W'(1)};
      end
      stack_rd_ff <= stack_mem[sp_ff - SLOT_W'(1)];
   end

   hcl_chain #(
      .CELLS   (LEAF_CAP),
      .DATA_W  (DATA_W),
      .KEY_LSB (NID_W)
   ) u_chain (
      .clock       (clock),
      .reset       (reset),
      .op          (chain_op),
      .ins_data    (ins_data),
      .head0_data  (head0_data),
      .head1_valid (head1_valid)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_symbol_out  = rsp_sym_ff;
   assign rsp_code_length = rsp_len_ff;
   assign rsp_last_leaf   = rsp_last_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

FILE: rtl/hcl_cell.sv
// One cell of the sorted node chain: holds one node, inserts or shifts with neighbors.
// Depends on hcl_pkg.
module hcl_cell #(
   parameter int DATA_W  = 60,
   parameter int KEY_LSB = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hcl_pkg::chain_op_type op,
   input  logic [DATA_W-1:0]    ins_data,
   input  logic                 prv_valid,
   input  logic                 prv_lt,
   input  logic [DATA_W-1:0]    prv_data,
   input  logic                 nxt_valid,
   input  logic [DATA_W-1:0]    nxt_data,
   output logic                 cell_valid,
   output logic [DATA_W-1:0]    cell_data,
   output logic                 cell_lt
);
   import hcl_pkg::*;

   logic              valid_ff, valid_in;
   logic [DATA_W-1:0] data_ff, data_in;

   // key = {weight, min symbol}
   assign cell_lt    = valid_ff && (data_ff[DATA_W-1:KEY_LSB] < ins_data[DATA_W-1:KEY_LSB]);
   assign cell_valid = valid_ff;
   assign cell_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      unique case (op)
         CH_HOLD: begin
         end
         CH_CLEAR: begin
            valid_in = 1'b0;
         end
         CH_INSERT: begin
            if (!cell_lt) begin
               if (prv_lt) begin
                  valid_in = 1'b1;
                  data_in  = ins_data;
               end else begin
                  valid_in = prv_valid;
                  data_in  = prv_data;
               end
            end
         end
         CH_POP: begin
            valid_in = nxt_valid;
            data_in  = nxt_data;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

FILE: rtl/hcl_chain.sv
// Row of hcl_cell instances kept sorted by key, least node at the head.
// Depends on hcl_pkg and hcl_cell.
module hcl_chain #(
   parameter int CELLS   = 512,
   parameter int DATA_W  = 60,
   parameter int KEY_LSB = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hcl_pkg::chain_op_type op,
   input  logic [DATA_W-1:0]    ins_data,
   output logic [DATA_W-1:0]    head0_data,
   output logic                 head1_valid
);
   import hcl_pkg::*;

   logic              valid_w [CELLS];
   logic              lt_w    [CELLS];
   logic [DATA_W-1:0] data_w  [CELLS];

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      logic              p_valid, p_lt, n_valid;
      logic [DATA_W-1:0] p_data, n_data;

      if (i == 0) begin : g_first
         assign p_valid = 1'b0;
         assign p_lt    = 1'b1;
         assign p_data  = '0;
      end else begin : g_mid
         assign p_valid = valid_w[i-1];
         assign p_lt    = lt_w[i-1];
         assign p_data  = data_w[i-1];
      end

      if (i == CELLS - 1) begin : g_last
         assign n_valid = 1'b0;
         assign n_data  = '0;
      end else begin : g_body
         assign n_valid = valid_w[i+1];
         assign n_data  = data_w[i+1];
      end

      hcl_cell #(
         .DATA_W  (DATA_W),
         .KEY_LSB (KEY_LSB)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (op),
         .ins_data   (ins_data),
         .prv_valid  (p_valid),
         .prv_lt     (p_lt),
         .prv_data   (p_data),
         .nxt_valid  (n_valid),
         .nxt_data   (n_data),
         .cell_valid (valid_w[i]),
         .cell_data  (data_w[i]),
         .cell_lt    (lt_w[i])
      );
   end

   assign head0_data  = data_w[0];
   assign head1_valid = valid_w[1];

endmodule

FILE: rtl/hcl_checker.sv
// Port-level checks for the Huffman code length builder, bound to the top level.
// Depends on hcl_pkg.
module hcl_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [hcl_pkg::SYM_W-1:0]     rsp_symbol_out,
   input logic [hcl_pkg::LEN_W-1:0]     rsp_code_length,
   input logic                          rsp_last_leaf,
   input logic                          rsp_status
);
   import hcl_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_symbol_out)
         && $stable(rsp_code_length) && $stable(rsp_last_leaf) && $stable(rsp_status))
      else $error("response changed while stalled");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |-> (rsp_symbol_out == '0)
         && (rsp_code_length == '0) && !rsp_last_leaf)
      else $error("empty status with nonzero fields");

   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken while index clears");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind huffman_code_length_builder hcl_checker u_hcl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_symbol_out  (rsp_symbol_out),
   .rsp_code_length (rsp_code_length),
   .rsp_last_leaf   (rsp_last_leaf),
   .rsp_status      (rsp_status)
);
